[hw/rtl/chacha_pkg.sv]
// Shared types and constants for the ChaCha20 stream cipher block.
// Used by chacha_ctrl, chacha_dp and the chacha20_stream_cipher top level.
`default_nettype none

package chacha_pkg;

   localparam int WordBits    = 32;
   localparam int CfgBits     = 64;
   localparam int BlockBytes  = 64;
   localparam int RoundSteps  = 80;   // 10 double rounds x 8 add/xor/rotate steps
   localparam int StepBits    = 7;
   localparam int PosBits     = 7;

   localparam logic [WordBits-1:0] SIGMA_0 = 32'h6170_7865;
   localparam logic [WordBits-1:0] SIGMA_1 = 32'h3320_646e;
   localparam logic [WordBits-1:0] SIGMA_2 = 32'h7962_2d32;
   localparam logic [WordBits-1:0] SIGMA_3 = 32'h6b20_6574;

   // configuration register indexes
   localparam logic [2:0] REG_KEY_PART_0      = 3'd0;
   localparam logic [2:0] REG_KEY_PART_1      = 3'd1;
   localparam logic [2:0] REG_KEY_PART_2      = 3'd2;
   localparam logic [2:0] REG_KEY_PART_3      = 3'd3;
   localparam logic [2:0] REG_NONCE_LOW       = 3'd4;
   localparam logic [2:0] REG_NONCE_HIGH      = 3'd5;
   localparam logic [2:0] REG_INITIAL_COUNTER = 3'd6;

   typedef struct packed {
      logic       load;       // copy initial state into working state
      logic       step;       // one add/xor/rotate step on all four lanes
      logic [1:0] phase;      // which of the four steps of a quarter round
      logic       diag;       // diagonal half of the double round
      logic       final_add;  // feed-forward add, counter increment
      logic       consume;    // input beat taken
   } dp_cmd_type;

   typedef struct packed {
      logic block_empty;      // no buffered keystream bytes left
      logic cfg_hit;          // write to a listed register this cycle
   } dp_status_type;

endpackage

`default_nettype wire

[hw/rtl/chacha20_stream_cipher.sv]
// ChaCha20 stream cipher, RFC 8439 state layout, one byte per beat.
// Top level: joins chacha_ctrl and chacha_dp. Uses chacha_pkg.
//
// Each request beat carries one byte (tlast marks the end of a call); the
// response beat is that byte XORed with the next keystream byte. While a
// block is buffered, one byte is taken per cycle while results are taken and no
// config write is pending, and the single output register lets the next byte
// enter in the same cycle that the waiting result is taken. A new 64-byte block
// is built when a byte arrives with nothing buffered: a start step loads the
// working state, the rounds run on the shared four-lane add/xor/rotate unit,
// and a feed-forward step fills the keystream buffer. A write to a listed config
// register reloads the block counter and drops the buffered block; such a write
// during block generation cancels it.
`default_nettype none

module chacha20_stream_cipher (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,  // [7:0] data_byte
   input  wire logic                           req_tlast,  // end_of_call
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [7:0] result_byte
   input  wire logic                           csr_we,
   input  wire logic [2:0]                     csr_index,
   input  wire logic [chacha_pkg::CfgBits-1:0] csr_wdata
);

   chacha_pkg::dp_cmd_type    cmd;
   chacha_pkg::dp_status_type status;

   chacha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .status     (status),
      .cmd        (cmd)
   );

   chacha_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .cmd       (cmd),
      .status    (status),
      .out_byte  (rsp_tdata)
   );

   // a taken beat always shows up at the output next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted beat produced no response");

   // bytes are only taken from a filled block
   a_consume_full: assert property (@(posedge clock) disable iff (reset)
      cmd.consume |-> !status.block_empty)
      else $error("byte consumed with no keystream buffered");

   // block generation and byte consumption never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (cmd.load || cmd.step || cmd.final_add) |-> !cmd.consume)
      else $error("consume during block generation");

endmodule

`default_nettype wire

[hw/rtl/chacha_dp.sv]
// Datapath of the ChaCha20 block: configuration registers, working state,
// shared quarter-round step lanes, keystream buffer and result byte. Uses chacha_pkg.
`default_nettype none

module chacha_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [2:0]                        csr_index,
   input  wire logic [chacha_pkg::CfgBits-1:0]    csr_wdata,
   input  wire logic [7:0]                        in_byte,
   input  wire logic                              in_last,
   input  wire chacha_pkg::dp_cmd_type            cmd,
   output chacha_pkg::dp_status_type              status,
   output logic [7:0]                             out_byte
);

   localparam int W = chacha_pkg::WordBits;

   logic [chacha_pkg::CfgBits-1:0] key_ff [4];
   logic [chacha_pkg::CfgBits-1:0] nonce_low_ff;
   logic [W-1:0]                   nonce_high_ff;
   logic [W-1:0]                   init_counter_ff;
   logic [W-1:0]                   counter_ff;
   logic [chacha_pkg::PosBits-1:0] pos_ff;
   logic [W-1:0]                   work_ff [16];
   logic [W-1:0]                   work_in [16];
   logic [W-1:0]                   ks_ff [16];
   logic [W-1:0]                   init_w [16];
   logic [7:0]                     out_byte_ff;
   logic [W-1:0]                   ks_word;
   logic [7:0]                     ks_byte;
   logic                           cfg_hit;

   function automatic logic [W-1:0] rotl(input logic [W-1:0] v, input logic [1:0] ph);
      logic [W-1:0] r;
      case (ph)
         2'd0:    r = {v[15:0], v[31:16]};
         2'd1:    r = {v[19:0], v[31:20]};
         2'd2:    r = {v[23:0], v[31:24]};
         default: r = {v[24:0], v[31:25]};
      endcase
      return r;
   endfunction

   assign cfg_hit = csr_we && (csr_index <= chacha_pkg::REG_INITIAL_COUNTER);

   always_comb begin
      init_w[0]  = chacha_pkg::SIGMA_0;
      init_w[1]  = chacha_pkg::SIGMA_1;
      init_w[2]  = chacha_pkg::SIGMA_2;
      init_w[3]  = chacha_pkg::SIGMA_3;
      for (int k = 0; k < 4; k++) begin
         init_w[4 + 2 * k] = key_ff[k][W-1:0];
         init_w[5 + 2 * k] = key_ff[k][2*W-1:W];
      end
      init_w[12] = counter_ff;
      init_w[13] = nonce_low_ff[W-1:0];
      init_w[14] = nonce_low_ff[2*W-1:W];
      init_w[15] = nonce_high_ff;
   end

   // four independent lanes; columns or diagonals picked by cmd.diag
   always_comb begin
      logic [3:0]   ia, ib, ic, id;
      logic [W-1:0] sum;
      work_in = work_ff;
      for (int i = 0; i < 4; i++) begin
         ia = 4'(i);
         ib = {2'b01, 2'(i + int'(cmd.diag))};
         ic = {2'b10, 2'(i + 2 * int'(cmd.diag))};
         id = {2'b11, 2'(i + 3 * int'(cmd.diag))};
         if (!cmd.phase[0]) begin
            sum         = work_ff[ia] + work_ff[ib];
            work_in[ia] = sum;
            work_in[id] = rotl(work_ff[id] ^ sum, cmd.phase);
         end else begin
            sum         = work_ff[ic] + work_ff[id];
            work_in[ic] = sum;
            work_in[ib] = rotl(work_ff[ib] ^ sum, cmd.phase);
         end
      end
   end

   assign ks_word = ks_ff[pos_ff[5:2]];

   always_comb begin
      case (pos_ff[1:0])
         2'd0:    ks_byte = ks_word[7:0];
         2'd1:    ks_byte = ks_word[15:8];
         2'd2:    ks_byte = ks_word[23:16];
         default: ks_byte = ks_word[31:24];
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) key_ff[k] <= '0;
         nonce_low_ff    <= '0;
         nonce_high_ff   <= '0;
         init_counter_ff <= '0;
         counter_ff      <= '0;
         pos_ff          <= chacha_pkg::PosBits'(chacha_pkg::BlockBytes);
      end else if (cfg_hit) begin
         unique case (csr_index)
            chacha_pkg::REG_KEY_PART_0: key_ff[0] <= csr_wdata;
            chacha_pkg::REG_KEY_PART_1: key_ff[1] <= csr_wdata;
            chacha_pkg::REG_KEY_PART_2: key_ff[2] <= csr_wdata;
            chacha_pkg::REG_KEY_PART_3: key_ff[3] <= csr_wdata;
            chacha_pkg::REG_NONCE_LOW:  nonce_low_ff <= csr_wdata;
            chacha_pkg::REG_NONCE_HIGH: nonce_high_ff <= csr_wdata[W-1:0];
            default:                    init_counter_ff <= csr_wdata[W-1:0];
         endcase
         counter_ff <= (csr_index == chacha_pkg::REG_INITIAL_COUNTER) ?
                       csr_wdata[W-1:0] : init_counter_ff;
         pos_ff     <= chacha_pkg::PosBits'(chacha_pkg::BlockBytes);
      end else if (cmd.final_add) begin
         counter_ff <= counter_ff + W'(1);
         pos_ff     <= '0;
      end else if (cmd.consume) begin
         pos_ff <= in_last ? chacha_pkg::PosBits'(chacha_pkg::BlockBytes) :
                   pos_ff + chacha_pkg::PosBits'(1);
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         work_ff <= init_w;
      end else if (cmd.step) begin
         work_ff <= work_in;
      end
      if (cmd.final_add && !cfg_hit) begin
         for (int k = 0; k < 16; k++) ks_ff[k] <= work_ff[k] + init_w[k];
      end
      if (cmd.consume) begin
         out_byte_ff <= in_byte ^ ks_byte;
      end
   end

   assign status.block_empty = pos_ff[6];
   assign status.cfg_hit     = cfg_hit;
   assign out_byte           = out_byte_ff;

endmodule

`default_nettype wire

[hw/rtl/chacha_ctrl.sv]
// Controller of the ChaCha20 block: sequences block generation over the
// shared step lanes and runs the input/output handshake. Uses chacha_pkg.
`default_nettype none

module chacha_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic                        csr_we,
   input  wire chacha_pkg::dp_status_type   status,
   output chacha_pkg::dp_cmd_type           cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL
   } state_type;

   state_type                        state_ff;
   logic [chacha_pkg::StepBits-1:0]  step_ff;
   logic                             rsp_valid_ff;
   logic                             out_free;
   logic                             start;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !status.block_empty && out_free && !csr_we;
   assign start      = (state_ff == ST_IDLE) && status.block_empty && req_tvalid &&
                       !status.cfg_hit;

   always_comb begin
      cmd           = '0;
      cmd.load      = start;
      cmd.step      = (state_ff == ST_ROUND);
      cmd.phase     = step_ff[1:0];
      cmd.diag      = step_ff[2];
      cmd.final_add = (state_ff == ST_FINAL);
      cmd.consume   = req_tvalid && req_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.consume) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         // a config write mid-block throws the partial block away
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_ROUND;
                  step_ff  <= '0;
               end
            end
            ST_ROUND: begin
               if (status.cfg_hit) begin
                  state_ff <= ST_IDLE;
               end else if (step_ff == chacha_pkg::StepBits'(chacha_pkg::RoundSteps - 1)) begin
                  state_ff <= ST_FINAL;
               end
               step_ff <= step_ff + chacha_pkg::StepBits'(1);
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

[tb/chacha20_stream_cipher_test.sv]
// Self-checking testbench for the chacha20_stream_cipher block.
// Drives byte beats and csr writes, predicts every response beat in-house.
// Depends on chacha_pkg and the chacha20_stream_cipher RTL.
`timescale 1ns / 1ps

module chacha20_stream_cipher_test;

   localparam int          CLOCK_PERIOD  = 10;
   localparam int          RESET_CYCLES  = 5;
   localparam int          DRAIN_CYCLES  = 6;
   localparam int          LONG_HOLD     = 300;
   localparam int          RANDOM_PHASES = 6;
   localparam int          PHASE_BEATS   = 75;
   localparam int          MAX_GAP       = 8;
   localparam logic [2:0]  REG_UNUSED    = 3'd7;   // not a listed register

   typedef enum logic [1:0] {ROW_BYTE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   index;
      logic [63:0]  value;
      logic [7:0]   data;
      logic         eoc;
      logic         typed;   // want holds a hand-checked value
      logic [7:0]   want;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [7:0]                     req_tdata;
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [7:0]                     rsp_tdata;
   logic                           csr_we;
   logic [2:0]                     csr_index;
   logic [chacha_pkg::CfgBits-1:0] csr_wdata;

   // cipher state mirror
   logic [63:0]  key_reg[4];
   logic [63:0]  nonce_low_reg;
   logic [31:0]  nonce_high_reg;
   logic [31:0]  counter_init_reg;
   logic [31:0]  block_count;
   logic [31:0]  ks_words[16];
   logic [31:0]  mix[16];
   logic [6:0]   ks_pos;

   logic [7:0]   expected_bytes[$];
   stim_row_type directed_rows[$];

   int  fail_count;
   int  beats_sent;
   int  beats_checked;
   int  csr_writes;
   int  blocks_built;
   int  send_calm;
   int  recv_calm;
   bit  hold_request;
   bit  hold_done;

   chacha20_stream_cipher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void quarter_round(int a, int b, int c, int d);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl32(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl32(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl32(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl32(mix[b] ^ mix[c], 7);
   endfunction

   function automatic void refill_keystream();
      logic [31:0] init_words[16];
      int k;
      init_words[0] = chacha_pkg::SIGMA_0;
      init_words[1] = chacha_pkg::SIGMA_1;
      init_words[2] = chacha_pkg::SIGMA_2;
      init_words[3] = chacha_pkg::SIGMA_3;
      for (k = 0; k < 4; k++) begin
         init_words[4 + 2 * k] = key_reg[k][31:0];
         init_words[5 + 2 * k] = key_reg[k][63:32];
      end
      init_words[12] = block_count;
      init_words[13] = nonce_low_reg[31:0];
      init_words[14] = nonce_low_reg[63:32];
      init_words[15] = nonce_high_reg;
      mix = init_words;
      for (k = 0; k < 10; k++) begin
         quarter_round(0, 4, 8, 12);
         quarter_round(1, 5, 9, 13);
         quarter_round(2, 6, 10, 14);
         quarter_round(3, 7, 11, 15);
         quarter_round(0, 5, 10, 15);
         quarter_round(1, 6, 11, 12);
         quarter_round(2, 7, 8, 13);
         quarter_round(3, 4, 9, 14);
      end
      for (k = 0; k < 16; k++) ks_words[k] = mix[k] + init_words[k];
      block_count = block_count + 32'd1;   // wraps at 2^32
      blocks_built++;
   endfunction

   function automatic logic [7:0] cipher_byte(logic [7:0] data, logic eoc);
      logic [31:0] word;
      logic [7:0]  ks;
      if (ks_pos >= 7'(chacha_pkg::BlockBytes)) begin
         refill_keystream();
         ks_pos = '0;
      end
      word = ks_words[ks_pos[5:2]];
      ks = word[8 * ks_pos[1:0] +: 8];
      ks_pos = ks_pos + 7'd1;
      if (eoc) ks_pos = 7'(chacha_pkg::BlockBytes);   // rest of the block is dropped
      return data ^ ks;
   endfunction

   function automatic void apply_csr(logic [2:0] index, logic [63:0] value);
      case (index)
         chacha_pkg::REG_KEY_PART_0:      key_reg[0] = value;
         chacha_pkg::REG_KEY_PART_1:      key_reg[1] = value;
         chacha_pkg::REG_KEY_PART_2:      key_reg[2] = value;
         chacha_pkg::REG_KEY_PART_3:      key_reg[3] = value;
         chacha_pkg::REG_NONCE_LOW:       nonce_low_reg = value;
         chacha_pkg::REG_NONCE_HIGH:      nonce_high_reg = value[31:0];
         chacha_pkg::REG_INITIAL_COUNTER: counter_init_reg = value[31:0];
         default:                         return;
      endcase
      block_count = counter_init_reg;
      ks_pos = 7'(chacha_pkg::BlockBytes);
   endfunction

   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_beat(logic [7:0] data, logic eoc, int gap, logic typed,
                            logic [7:0] want);
      logic [7:0] predicted;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tlast  = eoc;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = cipher_byte(data, eoc);
      expected_bytes.push_back(typed ? want : predicted);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] index, logic [63:0] value);
      wait_drained();
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      apply_csr(index, value);
      csr_writes++;
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 64'd0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // response side: random stalls, one long hold-off on request
   initial begin
      int stall;
      logic [7:0] want;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready   = 1'b0;
            hold_request = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done = 1'b1;
         end
         stall = draw_gap(recv_calm);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (expected_bytes.size() == 0) begin
            $error("result_byte: expected none, actual %02h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want) begin
               $error("result_byte: expected %02h, actual %02h", want, rsp_tdata);
               fail_count++;
            end
            beats_checked++;
         end
      end
   end

   initial begin
      stim_row_type row;
      int phase;
      int n;
      int r;
      int eoc_odds;
      logic [7:0] data;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      fail_count = 0;
      beats_sent = 0;
      beats_checked = 0;
      csr_writes = 0;
      blocks_built = 0;
      send_calm  = 0;
      recv_calm  = 0;
      hold_request = 1'b0;
      hold_done  = 1'b0;
      for (r = 0; r < 4; r++) key_reg[r] = '0;
      nonce_low_reg    = '0;
      nonce_high_reg   = '0;
      counter_init_reg = '0;
      block_count      = '0;
      ks_pos           = 7'(chacha_pkg::BlockBytes);

      // zero key and nonce after reset, then the known-answer block, then extremes
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'h76});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'hb8});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'he0});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'had});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'hff, 1'b0, 1'b1, 8'h5f});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b1, 1'b1, 8'hf1});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h5a, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_KEY_PART_0,
                                             64'h0706050403020100, 8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_KEY_PART_1,
                                             64'h0f0e0d0c0b0a0908, 8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_KEY_PART_2,
                                             64'h1716151413121110, 8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_KEY_PART_3,
                                             64'h1f1e1d1c1b1a1918, 8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_NONCE_LOW,
                                             64'h4a000000_09000000, 8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_NONCE_HIGH,
                                             64'd0, 8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_INITIAL_COUNTER,
                                             64'd1, 8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'h10});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'hf1});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'he7});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'he4});
      // unlisted index: block keeps its place in the buffered block
      directed_rows.push_back(stim_row_type'{ROW_WRITE, REG_UNUSED, '1,
                                             8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'ha5, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_KEY_PART_0, '1,
                                             8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_KEY_PART_1, '1,
                                             8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_KEY_PART_2, '1,
                                             8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_KEY_PART_3, '1,
                                             8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_NONCE_LOW, '1,
                                             8'h00, 1'b0, 1'b0, 8'h00});
      // upper half beyond the register width
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_NONCE_HIGH, '1,
                                             8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_INITIAL_COUNTER, '1,
                                             8'h00, 1'b0, 1'b0, 8'h00});
      // counter wrap: end of call forces the next block right away
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'hff, 1'b1, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h80, 1'b1, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h01, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_WRITE, chacha_pkg::REG_INITIAL_COUNTER,
                                             64'd0, 8'h00, 1'b0, 1'b0, 8'h00});
      directed_rows.push_back(stim_row_type'{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b1, 1'b0, 8'h00});

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) write_csr(row.index, row.value);
         else send_beat(row.data, row.eoc, draw_gap(send_calm), row.typed, row.want);
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (r = 0; r < 7; r++) begin
            if ($urandom_range(0, 2) != 0) write_csr(3'(r), pick_value());
         end
         if (phase == 1) begin
            write_csr(chacha_pkg::REG_INITIAL_COUNTER,
                      64'(32'hffff_ffff - $urandom_range(0, 3)));
         end
         if ($urandom_range(0, 3) == 0) write_csr(REG_UNUSED, {$urandom, $urandom});
         case (phase % 3)
            0:       eoc_odds = 16;
            1:       eoc_odds = 4;
            default: eoc_odds = 64;
         endcase
         if (phase == 2) begin
            hold_done    = 1'b0;
            hold_request = 1'b1;
         end
         for (n = 0; n < PHASE_BEATS; n++) begin
            case ($urandom_range(0, 9))
               0:       data = 8'h00;
               1:       data = 8'hff;
               default: data = 8'($urandom);
            endcase
            // sender keeps pushing back-to-back while the receiver holds off
            send_beat(data, $urandom_range(0, eoc_odds - 1) == 0,
                      (phase == 2 && n < 40) ? 0 : draw_gap(send_calm), 1'b0, 8'h00);
            if (phase == 3 && n == PHASE_BEATS / 2) begin
               req_tvalid = 1'b0;
               while (expected_bytes.size() != 0) @(negedge clock);
            end
         end
      end

      req_tvalid = 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Sent %0d byte beats, checked %0d, across %0d csr writes.",
               beats_sent, beats_checked, csr_writes);
      $display("Keystream blocks predicted: %0d, long receiver hold-off done: %0d.",
               blocks_built, hold_done);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

[chacha20_stream_cipher.f]
hw/rtl/chacha_pkg.sv
hw/rtl/chacha_dp.sv
hw/rtl/chacha_ctrl.sv
hw/rtl/chacha20_stream_cipher.sv
tb/chacha20_stream_cipher_test.sv
